>>> design/ntps_pkg.sv
// Shared types and constants for the neighbour table and parent selection block.
package ntps_pkg;

    localparam logic OP_BEACON = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic signed [15:0] RSSI_MIN  = 16'sh8000;
    localparam logic signed [15:0] RSSI_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] PATH_ROOT = -16'sd1;

    typedef struct packed {
        logic               op;
        logic        [15:0] sender_id;
        logic signed [15:0] advertised_rssi;
        logic signed [7:0]  link_rssi;
    } req_t;

    typedef struct packed {
        logic        [15:0] parent_id;
        logic signed [15:0] path_rssi;
        logic               reselected;
        logic               dropped;
    } rsp_t;

    // Beacon travelling down the row of cells together with the running best entry.
    typedef struct packed {
        logic               active;
        logic        [15:0] sender_id;
        logic signed [15:0] advertised_rssi;
        logic signed [7:0]  link_rssi;
        logic               hit;
        logic               better;
        logic signed [15:0] best_adv;
        logic signed [15:0] best_path;
        logic        [15:0] best_id;
    } wave_t;

endpackage

>>> design/ntps_cell.sv
// One neighbour table entry, which updates itself and the running best as a beacon passes.
module ntps_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clr,
    input  ntps_pkg::wave_t wave_in,
    output ntps_pkg::wave_t wave_out
);
    import ntps_pkg::*;

    logic               valid_reg;
    logic        [15:0] id_reg;
    logic signed [15:0] adv_reg;
    logic signed [7:0]  link_reg;
    wave_t              wave_reg;
    wave_t              wave_next;

    logic               match;
    logic               append;
    logic               upd;
    logic               eff_valid;
    logic signed [15:0] eff_adv;
    logic signed [7:0]  eff_link;
    logic signed [16:0] sum;
    logic signed [15:0] path;

    always_comb
    begin
        match     = valid_reg && (id_reg == wave_in.sender_id);
        // Entries fill in order, so the first empty cell a missed beacon meets is the next slot.
        append    = !valid_reg && !wave_in.hit;
        upd       = wave_in.active && (match || append);
        eff_valid = valid_reg || append;
        eff_adv   = upd ? wave_in.advertised_rssi : adv_reg;
        eff_link  = upd ? wave_in.link_rssi : link_reg;
        sum       = {{9{eff_link[7]}}, eff_link} + {eff_adv[15], eff_adv};
        if (sum[16] != sum[15])
        begin
            path = sum[16] ? RSSI_MIN : RSSI_MAX;
        end
        else
        begin
            path = sum[15:0];
        end

        wave_next = wave_in;
        if (upd)
        begin
            wave_next.hit = 1'b1;
        end
        if (wave_in.active && eff_valid && (eff_adv > wave_in.best_adv))
        begin
            wave_next.better    = 1'b1;
            wave_next.best_adv  = eff_adv;
            wave_next.best_path = path;
            wave_next.best_id   = wave_in.sender_id;
            if (!upd)
            begin
                wave_next.best_id = id_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            wave_reg  <= '0;
        end
        else
        begin
            wave_reg <= wave_next;
            if (clr)
            begin
                valid_reg <= 1'b0;
            end
            else if (upd)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            id_reg   <= wave_in.sender_id;
            adv_reg  <= wave_in.advertised_rssi;
            link_reg <= wave_in.link_rssi;
        end
    end

    assign wave_out = wave_reg;

endmodule

>>> design/neighbor_table_parent_select.sv
// A beacon request enters a row of TABLE_DEPTH cells, one table entry each, and moves one cell
// per clock: each cell matches the sender, takes the first free slot for a new sender, and
// carries forward the best advertised entry, and the response is registered from the last cell.
// A clear request empties the table at once and answers in the next cycle. One request is in
// the row at a time; the next is taken once the response register is free. The root flag is
// set via cfg_wr_en / cfg_wr_data by the user only while the block is idle; not enforced.
module neighbor_table_parent_select #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           req_valid,
    output logic           req_ready,
    input  ntps_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ntps_pkg::rsp_t rsp
);
    import ntps_pkg::*;

    logic               is_root_reg;
    logic               busy_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic        [15:0] parent_addr_reg;
    logic signed [15:0] parent_path_reg;
    logic        [15:0] parent_addr_next;
    logic signed [15:0] parent_path_next;

    logic  accept;
    logic  clr;
    logic  done;
    wave_t wave [TABLE_DEPTH + 1];

    assign req_ready = !busy_reg && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign clr       = accept && (req.op == OP_CLEAR);

    always_comb
    begin
        wave[0].active          = accept && (req.op == OP_BEACON);
        wave[0].sender_id       = req.sender_id;
        wave[0].advertised_rssi = req.advertised_rssi;
        wave[0].link_rssi       = req.link_rssi;
        wave[0].hit             = 1'b0;
        wave[0].better          = 1'b0;
        wave[0].best_adv        = RSSI_MIN;
        wave[0].best_path       = RSSI_MIN;
        wave[0].best_id         = '0;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        ntps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clr      (clr),
            .wave_in  (wave[i]),
            .wave_out (wave[i + 1])
        );
    end

    assign done = wave[TABLE_DEPTH].active;

    always_comb
    begin
        parent_addr_next = parent_addr_reg;
        parent_path_next = parent_path_reg;
        rsp_next         = rsp_reg;
        if (done)
        begin
            if (wave[TABLE_DEPTH].hit && !is_root_reg && wave[TABLE_DEPTH].better)
            begin
                parent_addr_next = wave[TABLE_DEPTH].best_id;
                parent_path_next = wave[TABLE_DEPTH].best_path;
            end
            rsp_next.reselected = wave[TABLE_DEPTH].hit && !is_root_reg;
            rsp_next.dropped    = !wave[TABLE_DEPTH].hit;
        end
        else
        begin
            rsp_next.reselected = 1'b0;
            rsp_next.dropped    = 1'b0;
        end
        rsp_next.parent_id = parent_addr_next;
        rsp_next.path_rssi = is_root_reg ? PATH_ROOT : parent_path_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_root_reg     <= 1'b0;
            busy_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            parent_addr_reg <= '0;
            parent_path_reg <= RSSI_MIN;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                is_root_reg <= cfg_wr_data;
            end
            if (wave[0].active)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            if (done || clr)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            parent_addr_reg <= parent_addr_next;
            parent_path_reg <= parent_path_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done || clr)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> design/ntps_checker.sv
// Port-level checks for the neighbour table block, bound to its top level.
module ntps_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input ntps_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input ntps_pkg::rsp_t rsp
);
    import ntps_pkg::*;

    // A stalled response must hold.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // A response never reports both a reselection and a drop.
    a_rsp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.reselected && rsp.dropped))
        else $error("reselected and dropped both set");

    // A clear request answers in the next cycle with neither flag set.
    a_clear_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.op == OP_CLEAR)
        |=> rsp_valid && !rsp.reselected && !rsp.dropped)
        else $error("clear request not answered at once");

    // A beacon request needs the table scan, so no response follows at once and no request is taken.
    a_beacon_lat: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.op == OP_BEACON) |=> !rsp_valid && !req_ready)
        else $error("beacon answered without a table scan");

endmodule

bind neighbor_table_parent_select ntps_checker u_ntps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
